@@ hdl/awms_pkg.sv @@
// awms_pkg: widths, constants and state type for the above weighted mean selector
// used by awms_thresh and above_weighted_mean_selector_top; no dependencies
package awms_pkg;

    localparam int MAX_ENTRIES  = 64;
    localparam int PROB_W       = 16;
    localparam int IDX_W        = $clog2(MAX_ENTRIES);
    localparam int CNT_W        = $clog2(MAX_ENTRIES + 1);
    localparam int SUM_W        = PROB_W + IDX_W;
    localparam int WEIGHT_W     = 17;
    localparam int OUT_IDX_W    = 6;
    localparam int PROD_W       = SUM_W + CNT_W;
    localparam int CN_W         = 2 * CNT_W;
    localparam int RHS_W        = PROD_W + WEIGHT_W;
    localparam int FRAC_W       = 16;

    localparam logic [WEIGHT_W-1:0] ONE_Q16      = WEIGHT_W'(65536);
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(9830);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_MEAN,
        ST_THR_GO,
        ST_THR_WAIT,
        ST_SEL,
        ST_FLUSH
    } t_state;

endpackage

@@ hdl/above_weighted_mean_selector_top.sv @@
// Loads up to 64 probabilities, one per cycle while busy is low; the entry with
// i_last_entry set starts a pass over the entry memory (one read a cycle) that
// counts and sums the entries above the mean; if there are any, a threshold
// calculation and a second pass that selects the entries above it follow. The
// entry memory has a single read port with a registered output. Results come out on
// strobed ports for one cycle each and cannot be held off; the last one of a list
// carries o_last_result, and a list with nothing selected gives one result with
// o_found low. Entries past 64 are dropped. Write i_cfg_wdata only while idle.
// depends on awms_pkg and awms_thresh
module above_weighted_mean_selector_top
    import awms_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [WEIGHT_W-1:0]  i_cfg_wdata,
    input  logic                 start,
    output logic                 busy,
    input  logic [PROB_W-1:0]    i_probability,
    input  logic                 i_last_entry,
    output logic                 o_result_valid,
    output logic [OUT_IDX_W-1:0] o_entry_index,
    output logic                 o_found,
    output logic                 o_last_result
);

    logic [PROB_W-1:0] mem [MAX_ENTRIES];

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [SUM_W-1:0]   r_total, n_total;
    logic [CNT_W-1:0]   r_acnt, n_acnt;
    logic [SUM_W-1:0]   r_asum, n_asum;
    logic [IDX_W-1:0]   r_addr, n_addr;
    logic               r_issue, n_issue;
    logic               r_dv, n_dv;
    logic [IDX_W-1:0]   r_dv_idx, n_dv_idx;
    logic               r_dv_last, n_dv_last;
    logic               r_pend_vld, n_pend_vld;
    logic [IDX_W-1:0]   r_pend_idx, n_pend_idx;
    logic               r_out_valid, n_out_valid;
    logic [IDX_W-1:0]   r_out_idx, n_out_idx;
    logic               r_out_found, n_out_found;
    logic               r_out_last, n_out_last;
    logic               r_thr_go, n_thr_go;
    logic [WEIGHT_W-1:0] r_weight;
    logic [PROB_W-1:0]  r_rdata;

    logic               accept;
    logic               wr_en;
    logic [IDX_W-1:0]   last_addr;
    logic               mean_hit;
    logic               sel_hit;
    logic               thr_done;
    logic [RHS_W-1:0]   thr_rhs;
    logic [CN_W-1:0]    thr_cn;
    logic [RHS_W-1:0]   lhs;

    assign busy      = (r_state != ST_LOAD);
    assign accept    = start && !busy;
    assign wr_en     = accept && (r_count < CNT_W'(MAX_ENTRIES));
    assign last_addr = IDX_W'(r_count - CNT_W'(1));
    assign mean_hit  = ((PROB_W + CNT_W)'(r_rdata * r_count)) > (PROB_W + CNT_W)'(r_total);
    assign lhs       = {(RHS_W - FRAC_W)'(r_rdata * thr_cn), FRAC_W'(0)};
    assign sel_hit   = lhs > thr_rhs;

    awms_thresh u_thresh (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (r_thr_go),
        .i_weight    (r_weight),
        .i_above_cnt (r_acnt),
        .i_above_sum (r_asum),
        .i_entry_cnt (r_count),
        .i_total_sum (r_total),
        .o_done      (thr_done),
        .o_rhs       (thr_rhs),
        .o_cn        (thr_cn)
    );

    // entry memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_count[IDX_W-1:0]] <= i_probability;
        end
        if (r_issue) begin
            r_rdata <= mem[r_addr];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_total     = r_total;
        n_acnt      = r_acnt;
        n_asum      = r_asum;
        n_addr      = r_addr;
        n_issue     = r_issue;
        n_dv        = r_issue;
        n_dv_idx    = r_addr;
        n_dv_last   = r_issue && (r_addr == last_addr);
        n_pend_vld  = r_pend_vld;
        n_pend_idx  = r_pend_idx;
        n_out_valid = 1'b0;
        n_out_idx   = r_out_idx;
        n_out_found = r_out_found;
        n_out_last  = r_out_last;
        n_thr_go    = 1'b0;

        if (r_issue) begin
            n_addr = r_addr + IDX_W'(1);
            if (r_addr == last_addr) begin
                n_issue = 1'b0;
            end
        end

        unique case (r_state)
            ST_LOAD: begin
                if (accept) begin
                    if (wr_en) begin
                        n_count = r_count + CNT_W'(1);
                        n_total = r_total + SUM_W'(i_probability);
                    end
                    if (i_last_entry) begin
                        n_state = ST_MEAN;
                        n_issue = 1'b1;
                        n_addr  = '0;
                    end
                end
            end
            ST_MEAN: begin
                if (r_dv) begin
                    if (mean_hit) begin
                        n_acnt = r_acnt + CNT_W'(1);
                        n_asum = r_asum + SUM_W'(r_rdata);
                    end
                    if (r_dv_last) begin
                        n_state = ST_THR_GO;
                    end
                end
            end
            ST_THR_GO: begin
                if (r_acnt == '0) begin
                    n_state = ST_FLUSH;
                end else begin
                    n_thr_go = 1'b1;
                    n_state  = ST_THR_WAIT;
                end
            end
            ST_THR_WAIT: begin
                if (thr_done) begin
                    n_state    = ST_SEL;
                    n_issue    = 1'b1;
                    n_addr     = '0;
                    n_pend_vld = 1'b0;
                end
            end
            ST_SEL: begin
                // one hit held back so the final one can carry the last flag
                if (r_dv) begin
                    if (sel_hit) begin
                        if (r_pend_vld) begin
                            n_out_valid = 1'b1;
                            n_out_idx   = r_pend_idx;
                            n_out_found = 1'b1;
                            n_out_last  = 1'b0;
                        end
                        n_pend_vld = 1'b1;
                        n_pend_idx = r_dv_idx;
                    end
                    if (r_dv_last) begin
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                n_out_valid = 1'b1;
                n_out_idx   = r_pend_vld ? r_pend_idx : '0;
                n_out_found = r_pend_vld;
                n_out_last  = 1'b1;
                n_pend_vld  = 1'b0;
                n_count     = '0;
                n_total     = '0;
                n_acnt      = '0;
                n_asum      = '0;
                n_state     = ST_LOAD;
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_total     <= '0;
            r_acnt      <= '0;
            r_asum      <= '0;
            r_addr      <= '0;
            r_issue     <= 1'b0;
            r_dv        <= 1'b0;
            r_dv_last   <= 1'b0;
            r_pend_vld  <= 1'b0;
            r_out_valid <= 1'b0;
            r_thr_go    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_total     <= n_total;
            r_acnt      <= n_acnt;
            r_asum      <= n_asum;
            r_addr      <= n_addr;
            r_issue     <= n_issue;
            r_dv        <= n_dv;
            r_dv_last   <= n_dv_last;
            r_pend_vld  <= n_pend_vld;
            r_out_valid <= n_out_valid;
            r_thr_go    <= n_thr_go;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dv_idx    <= n_dv_idx;
        r_pend_idx  <= n_pend_idx;
        r_out_idx   <= n_out_idx;
        r_out_found <= n_out_found;
        r_out_last  <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= WEIGHT_RESET;
        end else if (i_cfg_we) begin
            r_weight <= i_cfg_wdata;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_entry_index  = OUT_IDX_W'(r_out_idx);
    assign o_found        = r_out_found;
    assign o_last_result  = r_out_last;

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_last_result |-> !busy)
        else $error("last item while still busy");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_found |-> o_last_result)
        else $error("empty item not marked last");

    a_read_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv |-> (r_state == ST_MEAN || r_state == ST_SEL))
        else $error("read data outside a scan");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ENTRIES))
        else $error("entry count overflow");

    a_thr_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        thr_done |-> r_state == ST_THR_WAIT)
        else $error("threshold done outside wait");

endmodule

@@ hdl/awms_thresh.sv @@
// awms_thresh: three stage product and sum for the selection threshold
// depends on awms_pkg
module awms_thresh
    import awms_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_go,
    input  logic [WEIGHT_W-1:0] i_weight,
    input  logic [CNT_W-1:0]    i_above_cnt,
    input  logic [SUM_W-1:0]    i_above_sum,
    input  logic [CNT_W-1:0]    i_entry_cnt,
    input  logic [SUM_W-1:0]    i_total_sum,
    output logic                o_done,
    output logic [RHS_W-1:0]    o_rhs,
    output logic [CN_W-1:0]     o_cn
);

    logic                r_v0, r_v1, r_v2;
    logic [PROD_W-1:0]   r_an, r_sc;
    logic [CN_W-1:0]     r_cn;
    logic [RHS_W-1:0]    r_t1, r_t2, r_rhs;
    logic [WEIGHT_W-1:0] w_sat;
    logic [WEIGHT_W-1:0] w_rest;

    // weights above one saturate
    assign w_sat  = (i_weight > ONE_Q16) ? ONE_Q16 : i_weight;
    assign w_rest = ONE_Q16 - w_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v0 <= i_go;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_an <= PROD_W'(i_above_sum * i_entry_cnt);
            r_sc <= PROD_W'(i_total_sum * i_above_cnt);
            r_cn <= CN_W'(i_above_cnt * i_entry_cnt);
        end
        if (r_v0) begin
            r_t1 <= RHS_W'(w_sat * r_an);
            r_t2 <= RHS_W'(w_rest * r_sc);
        end
        if (r_v1) begin
            r_rhs <= RHS_W'(r_t1 + r_t2);
        end
    end

    assign o_done = r_v2;
    assign o_rhs  = r_rhs;
    assign o_cn   = r_cn;

endmodule

@@ test/above_weighted_mean_selector_top_test.sv @@
`timescale 1ns / 1ps
// above_weighted_mean_selector_top_test: self-checking testbench for the above weighted mean
// selector; predicts the selected indexes of each list and checks every strobed result
// depends on awms_pkg and above_weighted_mean_selector_top
module above_weighted_mean_selector_top_test;
    import awms_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int SETTLE_CYCLES  = 16;
    localparam int TAIL_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PRINT_LIMIT    = 50;
    localparam int PHASE_ITEMS    = 14;

    localparam int STYLE_UNIFORM = 0;
    localparam int STYLE_LEVELS  = 1;
    localparam int STYLE_CLUSTER = 2;
    localparam int STYLE_FLAT    = 3;

    typedef struct packed {
        logic [PROB_W-1:0] prob;
        logic              last_entry;
        logic [7:0]        gap;
    } t_load_item;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] entry_index;
        logic                 found;
        logic                 last_result;
    } t_sel_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [WEIGHT_W-1:0]  cfg_wdata = '0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [PROB_W-1:0]    i_probability = '0;
    logic                 i_last_entry = 1'b0;
    logic                 o_result_valid;
    logic [OUT_IDX_W-1:0] o_entry_index;
    logic                 o_found;
    logic                 o_last_result;

    t_load_item  pending_items[$];
    t_sel_result expected_selections[$];

    // predictor state
    logic [PROB_W-1:0]   list_vals[MAX_ENTRIES];
    int unsigned         list_len = 0;
    longint unsigned     list_sum = 0;
    bit                  list_dropped = 0;
    logic [WEIGHT_W-1:0] weight_model = WEIGHT_RESET;

    int unsigned gap_left = 0;
    int unsigned items_loaded = 0;
    int unsigned lists_done = 0;
    int unsigned empty_lists = 0;
    int unsigned overflow_lists = 0;
    int unsigned results_seen = 0;
    int unsigned weights_written = 0;
    int unsigned stall_cycles = 0;
    int unsigned error_count = 0;
    bit          steady_phase = 0;

    above_weighted_mean_selector_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .start          (start),
        .busy           (busy),
        .i_probability  (i_probability),
        .i_last_entry   (i_last_entry),
        .o_result_valid (o_result_valid),
        .o_entry_index  (o_entry_index),
        .o_found        (o_found),
        .o_last_result  (o_last_result)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        if (error_count < PRINT_LIMIT) begin
            $display("ERROR at %0t: %s", $realtime, what);
        end
        error_count++;
    endtask

    // takes one accepted item; a last entry turns the stored list into expected selections
    task automatic absorb_entry(input logic [PROB_W-1:0] prob, input logic last_flag);
        longint unsigned n;
        longint unsigned c;
        longint unsigned a;
        longint unsigned w;
        longint unsigned v;
        longint unsigned rhs;
        int unsigned     sel_total;
        int unsigned     k;
        t_sel_result     r;
        if (list_len < MAX_ENTRIES) begin
            list_vals[list_len] = prob;
            list_len++;
            list_sum += prob;
        end else begin
            list_dropped = 1;
        end
        if (!last_flag) begin
            return;
        end
        n = list_len;
        c = 0;
        a = 0;
        sel_total = 0;
        rhs = 0;
        for (int i = 0; i < list_len; i++) begin
            v = list_vals[i];
            if (v * n > list_sum) begin
                c++;
                a += v;
            end
        end
        if (c != 0) begin
            w = (weight_model > ONE_Q16) ? ONE_Q16 : weight_model;
            rhs = w * a * n + (65536 - w) * list_sum * c;
            for (int i = 0; i < list_len; i++) begin
                v = list_vals[i];
                if (v * 65536 * c * n > rhs) begin
                    sel_total++;
                end
            end
        end
        k = 0;
        if (sel_total != 0) begin
            for (int i = 0; i < list_len; i++) begin
                v = list_vals[i];
                if (v * 65536 * c * n > rhs) begin
                    k++;
                    r.entry_index = OUT_IDX_W'(i);
                    r.found = 1'b1;
                    r.last_result = (k == sel_total);
                    expected_selections.insert(expected_selections.size(), r);
                end
            end
        end else begin
            r.entry_index = '0;
            r.found = 1'b0;
            r.last_result = 1'b1;
            expected_selections.insert(expected_selections.size(), r);
            empty_lists++;
        end
        if (list_dropped) begin
            overflow_lists++;
        end
        lists_done++;
        list_len = 0;
        list_sum = 0;
        list_dropped = 0;
    endtask

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (steady_phase || roll < 55) begin
            return 0;
        end else if (roll < 88) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic push_entry(input int unsigned prob, input bit last_flag);
        t_load_item itm;
        itm.prob = PROB_W'(prob);
        itm.last_entry = last_flag;
        itm.gap = 8'(pick_gap());
        pending_items.insert(pending_items.size(), itm);
    endtask

    task automatic queue_list(input int unsigned len, input int style);
        int unsigned levels[4];
        int unsigned base;
        int unsigned val;
        levels[0] = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 65535);
        levels[1] = $urandom_range(0, 3) == 0 ? 65535 : $urandom_range(0, 65535);
        levels[2] = $urandom_range(0, 65535);
        levels[3] = $urandom_range(0, 65535);
        base = $urandom_range(0, 65532);
        for (int i = 0; i < len; i++) begin
            case (style)
                STYLE_LEVELS:  val = levels[$urandom_range(0, 3)];
                STYLE_CLUSTER: val = base + $urandom_range(0, 3);
                STYLE_FLAT:    val = base;
                default:       val = $urandom_range(0, 65535);
            endcase
            push_entry(val, i == len - 1);
        end
    endtask

    function automatic int pick_style();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
            return STYLE_UNIFORM;
        end else if (roll < 75) begin
            return STYLE_LEVELS;
        end else if (roll < 90) begin
            return STYLE_CLUSTER;
        end
        return STYLE_FLAT;
    endfunction

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || start || expected_selections.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        while (busy) @(negedge i_clk);
    endtask

    task automatic write_weight(input int unsigned value);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= WEIGHT_W'(value);
        weight_model = WEIGHT_W'(value);
        weights_written++;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        t_load_item itm;
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_left = 0;
        end else begin
            if (start && !busy) begin
                absorb_entry(i_probability, i_last_entry);
                items_loaded++;
            end
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    itm = pending_items.pop_front();
                    start <= 1'b1;
                    i_probability <= itm.prob;
                    i_last_entry <= itm.last_entry;
                    gap_left = itm.gap;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        t_sel_result exp_sel;
        if (i_rst_n) begin
            if (o_result_valid || (start && !busy)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (o_result_valid) begin
                results_seen++;
                if (expected_selections.size() == 0) begin
                    report_mismatch($sformatf("unexpected result index %0d found %0b last %0b",
                        o_entry_index, o_found, o_last_result));
                end else begin
                    exp_sel = expected_selections.pop_front();
                    if (o_entry_index !== exp_sel.entry_index) begin
                        report_mismatch($sformatf("entry_index %0d, expected %0d",
                            o_entry_index, exp_sel.entry_index));
                    end
                    if (o_found !== exp_sel.found) begin
                        report_mismatch($sformatf("found %0b, expected %0b (index %0d)",
                            o_found, exp_sel.found, exp_sel.entry_index));
                    end
                    if (o_last_result !== exp_sel.last_result) begin
                        report_mismatch($sformatf("last_result %0b, expected %0b (index %0d)",
                            o_last_result, exp_sel.last_result, exp_sel.entry_index));
                    end
                end
            end
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no item or result for %0d cycles", WATCHDOG_LIMIT);
                $display("above_weighted_mean_selector_top_test: done, errors");
                $finish;
            end
        end
    end

    initial begin
        int unsigned weights[8];
        int unsigned phase_start;
        int unsigned len;
        weights[0] = 9830;
        weights[1] = 0;
        weights[2] = 65536;
        weights[3] = 1;
        weights[4] = 65535;
        weights[5] = $urandom_range(2, 65534);
        weights[6] = $urandom_range(65537, 131071);
        weights[7] = 32768;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset weight: single entry, extremes, all equal
        push_entry(0, 1);
        push_entry(65535, 0);
        push_entry(0, 1);
        push_entry(7, 0);
        push_entry(7, 0);
        push_entry(7, 1);
        push_entry(0, 0);
        push_entry(65535, 0);
        push_entry(0, 0);
        push_entry(65535, 0);
        push_entry(1, 0);
        push_entry(65534, 1);
        wait_idle();

        // full weight: equal above-mean entries leave nothing above the threshold
        write_weight(65536);
        push_entry(10, 0);
        push_entry(10, 0);
        push_entry(50, 0);
        push_entry(50, 1);
        push_entry(0, 0);
        push_entry(65535, 0);
        push_entry(65535, 1);
        wait_idle();

        // weight above one saturates
        write_weight(131071);
        push_entry(10, 0);
        push_entry(10, 0);
        push_entry(50, 0);
        push_entry(50, 1);
        wait_idle();

        // zero weight: threshold is the plain mean
        write_weight(0);
        push_entry(0, 0);
        push_entry(100, 0);
        push_entry(200, 1);
        wait_idle();

        for (int ph = 0; ph < 8; ph++) begin
            write_weight(weights[ph]);
            steady_phase = (ph % 3 == 1);
            phase_start = items_loaded + pending_items.size();
            if (ph == 2) begin
                queue_list(MAX_ENTRIES, STYLE_UNIFORM);
            end else if (ph == 5) begin
                queue_list($urandom_range(MAX_ENTRIES + 1, MAX_ENTRIES + 6), pick_style());
            end
            while (items_loaded + pending_items.size() - phase_start < PHASE_ITEMS) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40)
                                                  : $urandom_range(1, 10);
                queue_list(len, pick_style());
                if ($urandom_range(0, 6) == 0) begin
                    wait_idle();
                end
            end
            wait_idle();
        end
        steady_phase = 0;

        do @(negedge i_clk);
        while (pending_items.size() != 0 || start || expected_selections.size() != 0);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("covered %0d items in %0d lists (%0d overflowing, %0d with nothing selected)",
            items_loaded, lists_done, overflow_lists, empty_lists);
        $display("checked %0d results over %0d weight settings, %0d mismatches",
            results_seen, weights_written + 1, error_count);
        if (error_count == 0) begin
            $display("above_weighted_mean_selector_top_test: done, clean");
        end else begin
            $display("above_weighted_mean_selector_top_test: done, errors");
        end
        $finish;
    end

endmodule

@@ above_weighted_mean_selector_top.f @@
hdl/awms_pkg.sv
hdl/awms_thresh.sv
hdl/above_weighted_mean_selector_top.sv
test/above_weighted_mean_selector_top_test.sv
